// ----- sv/can_integrity_crc_pack_check_macros.svh -----
// Assertion macros shared by the CAN integrity CRC block.
`ifndef CAN_INTEGRITY_CRC_PACK_CHECK_MACROS_SVH
`define CAN_INTEGRITY_CRC_PACK_CHECK_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked on clk, quiet while rst is high.
`define CICC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Clocked on a given clock, checked in every cycle.
`define CICC_ASSERT_CLK(lbl, clock, prop) \
  lbl: assert property (@(posedge clock) prop) \
    else $error("assertion failed");
`else
`define CICC_ASSERT(lbl, prop)
`define CICC_ASSERT_CLK(lbl, clock, prop)
`endif

`endif

// ----- sv/cicc_pkg.sv -----
// Types, constants and CRC helper functions for the CAN integrity CRC block.
`default_nettype none

package cicc_pkg;

  // Default frame limit: four identifier bytes, payload, one sequence byte
  localparam int MaxFrameBytes = 10;
  localparam int IdBytes       = 4;

  // Configuration port
  localparam int AddrW = 5;
  localparam int DataW = 32;

  typedef enum logic [2:0] {
    REG_POLY        = 3'd0,
    REG_INIT_VALUE  = 3'd1,
    REG_FINAL_XOR   = 3'd2,
    REG_REFLECT_IN  = 3'd3,
    REG_REFLECT_OUT = 3'd4
  } cicc_reg_t;

  localparam logic [15:0] PolyReset      = 16'h1021;
  localparam logic [15:0] InitReset      = 16'hFFFF;
  localparam logic [15:0] FinalXorReset  = 16'h0000;

  typedef struct packed {
    logic [15:0] poly;
    logic [15:0] init_value;
    logic [15:0] final_xor;
    logic        reflect_in;
    logic        reflect_out;
  } cicc_cfg_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

  function automatic logic [15:0] rev16(input logic [15:0] v);
    logic [15:0] r;
    for (int k = 0; k < 16; k++) begin
      r[k] = v[15-k];
    end
    return r;
  endfunction

  // One byte through the MSB-first remainder, eight bit steps
  function automatic logic [15:0] crc_byte(input logic [15:0] rem_in,
                                           input logic [7:0]  b,
                                           input logic [15:0] p);
    logic [15:0] r;
    r = rem_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      r = r[15] ? ({r[14:0], 1'b0} ^ p) : {r[14:0], 1'b0};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- sv/cicc_if.sv -----
// Valid/ready channel interfaces for message items and result items.
`default_nettype none

interface cicc_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] can_id;
  logic [3:0]  dlc;
  logic [63:0] frame_data;
  logic [7:0]  seq_in;

  modport source (output valid, op, can_id, dlc, frame_data, seq_in, input ready);
  modport sink   (input valid, op, can_id, dlc, frame_data, seq_in, output ready);
endinterface

interface cicc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] msg_data;
  logic [15:0] mic;
  logic [7:0]  seq_out;
  logic        crc_ok;
  logic        dlc_error;

  modport source (output valid, msg_data, mic, seq_out, crc_ok, dlc_error, input ready);
  modport sink   (input valid, msg_data, mic, seq_out, crc_ok, dlc_error, output ready);
endinterface

`default_nettype wire

// ----- sv/cicc_cfg.sv -----
// APB register file holding the CRC settings.
`default_nettype none

module cicc_cfg import cicc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cicc_cfg_t        cfg
);

  cicc_reg_t reg_sel;
  logic      wr_en;

  assign pready  = 1'b1;
  assign reg_sel = cicc_reg_t'(paddr[AddrW-1:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // Write the addressed register; unknown addresses drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poly        <= PolyReset;
      cfg.init_value  <= InitReset;
      cfg.final_xor   <= FinalXorReset;
      cfg.reflect_in  <= 1'b0;
      cfg.reflect_out <= 1'b0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_POLY:        cfg.poly        <= pwdata[15:0];
        REG_INIT_VALUE:  cfg.init_value  <= pwdata[15:0];
        REG_FINAL_XOR:   cfg.final_xor   <= pwdata[15:0];
        REG_REFLECT_IN:  cfg.reflect_in  <= pwdata[0];
        REG_REFLECT_OUT: cfg.reflect_out <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    case (reg_sel)
      REG_POLY:        prdata = {16'h0000, cfg.poly};
      REG_INIT_VALUE:  prdata = {16'h0000, cfg.init_value};
      REG_FINAL_XOR:   prdata = {16'h0000, cfg.final_xor};
      REG_REFLECT_IN:  prdata = {31'h0, cfg.reflect_in};
      REG_REFLECT_OUT: prdata = {31'h0, cfg.reflect_out};
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/cicc_crc.sv -----
// Byte-serial CRC-16 remainder register with input and output reflection and final XOR.
`default_nettype none

module cicc_crc import cicc_pkg::*; (
  input  logic        clk,
  input  logic        start,
  input  logic        step,
  input  logic [7:0]  byte_in,
  input  cicc_cfg_t   cfg,
  output logic [15:0] crc
);

  logic [15:0] rem;
  logic [7:0]  byte_ord;
  logic [15:0] rem_out;

  assign byte_ord = cfg.reflect_in ? rev8(byte_in) : byte_in;

  // Load the initial remainder, then fold in one byte per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= cfg.init_value;
    end else if (step) begin
      rem <= crc_byte(rem, byte_ord, cfg.poly);
    end
  end

  // Finish the remainder
  assign rem_out = cfg.reflect_out ? rev16(rem) : rem;
  assign crc     = rem_out ^ cfg.final_xor;

endmodule

`default_nettype wire

// ----- sv/can_integrity_crc_pack_check.sv -----
// Top level of the CAN message integrity block: byte sequencer and result register.
//
// Usage:
//   req carries one CAN message per item (op, can_id, dlc, frame_data, seq_in);
//   rsp carries one result item per message. Both use valid/ready; an item
//   moves at a rising edge with valid and ready high.
//   op 0 seals the message: payload, sequence byte and big-endian CRC in
//   msg_data. op 1 checks it: the sequence byte and received CRC are taken
//   from the bytes after the payload; crc_ok compares the received CRC to the computed one.
//   The APB port sets poly, init_value, final_xor, reflect_in, reflect_out;
//   write it only while no message is in flight.
// Timing:
//   The frame is fed through one shift register into the CRC unit one byte
//   per cycle: plen + 5 bytes, plen = min(dlc - 3, MAX_FRAME_BYTES - 5).
//   The result is registered in the FINISH state and req.ready rises with
//   it, so a new message is accepted only once the previous one has left
//   the sequencer.
//   A dlc below 3 skips the CRC and goes straight from IDLE to FINISH.
// Reset clears the sequencer and drops any pending result. When the
// receiver stalls, the result register holds; one more message may run
// and then waits for the result register to free up.
`default_nettype none

`include "can_integrity_crc_pack_check_macros.svh"

module can_integrity_crc_pack_check import cicc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MaxFrameBytes
) (
  input  logic             clk,
  input  logic             rst,
  cicc_in_if.sink          req,
  cicc_out_if.source       rsp,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  localparam int          CntW     = $clog2(MAX_FRAME_BYTES);
  localparam logic [3:0]  MaxPlen  = 4'(MAX_FRAME_BYTES - 5);
  localparam logic [3:0]  DlcMin   = 4'd3;

  typedef enum logic [1:0] {IDLE, RUN, FINISH} state_t;

  state_t          state;
  cicc_cfg_t       cfg;
  logic [95:0]     shreg;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] last;
  logic            op_r;
  logic            err;
  logic [7:0]      seq_r;
  logic [7:0][7:0] dout;
  logic [7:0][7:0] fin_data;
  logic [3:0]      plen_raw;
  logic [3:0]      plen_c;
  logic [2:0]      pay_idx;
  logic [2:0]      plen3;
  logic [7:0]      feed_byte;
  logic [15:0]     crc;
  logic            accept;
  logic            crc_match;

  logic            out_valid;
  logic [63:0]     out_data;
  logic [15:0]     out_mic;
  logic [7:0]      out_seq;
  logic            out_ok;
  logic            out_err;

  cicc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cicc_crc u_crc (
    .clk     (clk),
    .start   (accept),
    .step    (state == RUN),
    .byte_in (feed_byte),
    .cfg     (cfg),
    .crc     (crc)
  );

  assign req.ready = (state == IDLE);
  assign accept    = req.valid && req.ready;

  // Clamp the payload length
  always_comb begin
    plen_raw = req.dlc - DlcMin;
    plen_c   = (plen_raw > MaxPlen) ? MaxPlen : plen_raw;
  end

  // Sealing swaps the sequence byte in for the last frame byte
  assign feed_byte = ((cnt == last) && !op_r) ? seq_r : shreg[95:88];
  assign pay_idx   = 3'(cnt - CntW'(IdBytes));
  assign plen3     = 3'(last - CntW'(IdBytes));

  // Received CRC sits at the top of the shift register once the frame is in
  assign crc_match = (shreg[95:80] == crc);

  // Place the CRC after the sequence byte when sealing
  always_comb begin
    fin_data = dout;
    if (!op_r) begin
      fin_data[~3'(plen3 + 3'd1)] = crc[15:8];
      fin_data[~3'(plen3 + 3'd2)] = crc[7:0];
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && rsp.ready && (state != FINISH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (accept) begin
            shreg <= {req.can_id, req.frame_data};
            op_r  <= req.op;
            seq_r <= req.seq_in;
            cnt   <= '0;
            last  <= CntW'(plen_c) + CntW'(IdBytes);
            dout  <= '0;
            err   <= (req.dlc < DlcMin);
            state <= (req.dlc < DlcMin) ? FINISH : RUN;
          end
        end
        RUN: begin
          // Advance one frame byte
          shreg <= {shreg[87:0], 8'h00};
          cnt   <= cnt + CntW'(1);
          if ((cnt >= CntW'(IdBytes)) && ((cnt != last) || !op_r)) begin
            dout[~pay_idx] <= feed_byte;
          end
          if (cnt == last) begin
            seq_r <= feed_byte;
            state <= FINISH;
          end
        end
        FINISH: begin
          // Hold until the result register is free
          if (!out_valid || rsp.ready) begin
            out_valid <= 1'b1;
            out_err   <= err;
            if (err) begin
              out_data <= '0;
              out_mic  <= '0;
              out_seq  <= '0;
              out_ok   <= 1'b0;
            end else begin
              out_data <= fin_data;
              out_mic  <= crc;
              out_seq  <= seq_r;
              out_ok   <= op_r && crc_match;
            end
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.msg_data  = out_data;
  assign rsp.mic       = out_mic;
  assign rsp.seq_out   = out_seq;
  assign rsp.crc_ok    = out_ok;
  assign rsp.dlc_error = out_err;

  `CICC_ASSERT(a_err_zero, out_valid && out_err |-> out_data == '0 && out_mic == '0 && !out_ok)
  `CICC_ASSERT(a_cnt_range, state == RUN |-> cnt <= last)
  `CICC_ASSERT(a_busy_after_accept, req.valid && req.ready |=> !req.ready)
  `CICC_ASSERT(a_out_from_finish, $rose(rsp.valid) |-> $past(state == FINISH))

endmodule

`default_nettype wire
